// ===== sv/smct_pkg.sv =====
// Shared types, codes and slot arithmetic for the saturating multiset counter table.
`default_nettype none
package smct_pkg;

  localparam int TOTAL_W = 14;
  localparam int WORD_W  = 16;
  localparam int CNT_W   = 2;
  localparam int SLOTS   = 8;
  localparam logic [CNT_W-1:0] COUNT_MAX = 2'd3;

  localparam logic [2:0] OP_ADD       = 3'd0;
  localparam logic [2:0] OP_REMOVE    = 3'd1;
  localparam logic [2:0] OP_COUNT     = 3'd2;
  localparam logic [2:0] OP_INTERSECT = 3'd3;
  localparam logic [2:0] OP_UNION     = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  bank;
    logic [11:0] value;
    logic [1:0]  other_bank;
    logic [1:0]  dest_bank;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]   element_count;
    logic [TOTAL_W-1:0] bank_total;
    logic               changed;
  } out_word_t;

  typedef enum logic [1:0] {
    K_ZERO   = 2'd0,
    K_REPORT = 2'd1,
    K_SINGLE = 2'd2,
    K_SET    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t    kind;
    in_word_t item;
  } job_t;

  function automatic logic [CNT_W-1:0] merge_cnt(input logic [CNT_W-1:0] ca,
                                                 input logic [CNT_W-1:0] cb,
                                                 input logic is_union);
    logic [CNT_W:0] sum;
    sum = {1'b0, ca} + {1'b0, cb};
    if (is_union) begin
      merge_cnt = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[CNT_W-1:0];
    end else begin
      merge_cnt = (ca < cb) ? ca : cb;
    end
  endfunction

endpackage
`default_nettype wire

// ===== sv/smct_front.sv =====
// Front part: classifies incoming words and holds them in a two-entry queue.
`default_nettype none
module smct_front #(
  parameter int NUM_BANKS  = 4,
  parameter int NUM_VALUES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear_done,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire smct_pkg::in_word_t item,
  output logic                   job_valid,
  output smct_pkg::job_t         job,
  input  wire logic              job_pop
);

  smct_pkg::job_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic [1:0]     fill_next;
  logic           push;
  logic           bank_ok;
  logic           other_ok;
  logic           dest_ok;
  logic           value_ok;
  smct_pkg::kind_t kind;

  assign bank_ok  = 32'(item.bank) < NUM_BANKS;
  assign other_ok = 32'(item.other_bank) < NUM_BANKS;
  assign dest_ok  = 32'(item.dest_bank) < NUM_BANKS;
  assign value_ok = 32'(item.value) < NUM_VALUES;

  always_comb begin
    case (item.operation)
      smct_pkg::OP_ADD, smct_pkg::OP_REMOVE, smct_pkg::OP_COUNT: begin
        if (!bank_ok) begin
          kind = smct_pkg::K_ZERO;
        end else if (value_ok) begin
          kind = smct_pkg::K_SINGLE;
        end else begin
          kind = smct_pkg::K_REPORT;
        end
      end
      smct_pkg::OP_INTERSECT, smct_pkg::OP_UNION: begin
        kind = (bank_ok && other_ok && dest_ok) ? smct_pkg::K_SET : smct_pkg::K_ZERO;
      end
      default: begin
        kind = bank_ok ? smct_pkg::K_REPORT : smct_pkg::K_ZERO;
      end
    endcase
  end

  assign item_ready = clear_done && (fill != 2'd2);
  assign push       = item_valid && item_ready;
  assign job_valid  = (fill != 2'd0);
  assign job        = q[rd_ptr];

  always_comb begin
    fill_next = fill;
    if (push && !job_pop) begin
      fill_next = fill + 2'd1;
    end else if (!push && job_pop) begin
      fill_next = fill - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      fill <= fill_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (job_pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{kind: kind, item: item};
    end
  end

endmodule
`default_nettype wire

// ===== sv/smct_back.sv =====
// Back part: counter memory, bank totals, word walk for set operations and result register.
`default_nettype none
module smct_back #(
  parameter int NUM_BANKS  = 4,
  parameter int NUM_VALUES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                job_valid,
  input  wire smct_pkg::job_t      job,
  output logic                     job_pop,
  output logic                     clear_done,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output smct_pkg::out_word_t      result
);

  localparam int WPB       = (NUM_VALUES + 7) / 8;
  localparam int WAW       = (WPB > 1) ? $clog2(WPB) : 1;
  localparam int BW        = $clog2(NUM_BANKS);
  localparam int AW        = BW + WAW;
  localparam int DEPTH     = 1 << AW;
  localparam int TOT_DEPTH = 1 << BW;
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WPB - 1);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SINGLE = 4'b0100,
    ST_SET    = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [smct_pkg::WORD_W-1:0]  mem [DEPTH];
  logic [smct_pkg::TOTAL_W-1:0] totals [TOT_DEPTH];
  logic [smct_pkg::WORD_W-1:0]  rd_a;
  logic [smct_pkg::WORD_W-1:0]  rd_b;
  logic [AW-1:0]                clr_addr;
  smct_pkg::job_t               cur;
  logic [WAW-1:0]               word_idx;
  logic [WAW-1:0]               next_word;
  logic [smct_pkg::TOTAL_W-1:0] acc;
  smct_pkg::out_word_t          out_word;

  logic                         out_free;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr_a;
  logic [AW-1:0]                rd_addr_b;
  logic                         we;
  logic [AW-1:0]                wr_addr;
  logic [smct_pkg::WORD_W-1:0]  wr_data;
  logic                         tot_we;
  logic [BW-1:0]                tot_idx;
  logic [smct_pkg::TOTAL_W-1:0] tot_wdata;
  logic [smct_pkg::TOTAL_W-1:0] tot_rd;
  logic                         emit;
  smct_pkg::out_word_t          emit_word;

  logic [BW-1:0]                job_bank;
  logic [BW-1:0]                job_other;
  logic [WAW-1:0]               job_word;
  logic [BW-1:0]                cur_bank;
  logic [BW-1:0]                cur_other;
  logic [BW-1:0]                cur_dest;
  logic [WAW-1:0]               cur_word;
  logic [2:0]                   cur_slot;
  logic                         last;

  logic [smct_pkg::CNT_W-1:0]   old_cnt;
  logic [smct_pkg::CNT_W-1:0]   new_cnt;
  logic                         chg;
  logic [smct_pkg::WORD_W-1:0]  single_word;
  logic [smct_pkg::TOTAL_W-1:0] single_total;
  logic [smct_pkg::WORD_W-1:0]  set_word;
  logic [4:0]                   word_sum;
  logic [smct_pkg::TOTAL_W-1:0] set_total;

  assign job_bank  = BW'(job.item.bank);
  assign job_other = BW'(job.item.other_bank);
  assign job_word  = WAW'(job.item.value >> 3);
  assign cur_bank  = BW'(cur.item.bank);
  assign cur_other = BW'(cur.item.other_bank);
  assign cur_dest  = BW'(cur.item.dest_bank);
  assign cur_word  = WAW'(cur.item.value >> 3);
  assign cur_slot  = cur.item.value[2:0];
  assign last      = (word_idx == LAST_WORD);
  assign next_word = word_idx + 1'b1;

  assign out_free     = !result_valid || result_ready;
  assign clear_done   = (state != ST_CLEAR);
  assign result       = out_word;
  assign tot_rd       = totals[tot_idx];

  always_comb begin
    old_cnt = rd_a[{cur_slot, 1'b0} +: smct_pkg::CNT_W];
    new_cnt = old_cnt;
    chg     = 1'b0;
    if (cur.item.operation == smct_pkg::OP_ADD && old_cnt != smct_pkg::COUNT_MAX) begin
      new_cnt = old_cnt + 2'd1;
      chg     = 1'b1;
    end else if (cur.item.operation == smct_pkg::OP_REMOVE && old_cnt != 2'd0) begin
      new_cnt = old_cnt - 2'd1;
      chg     = 1'b1;
    end
    single_word = rd_a;
    single_word[{cur_slot, 1'b0} +: smct_pkg::CNT_W] = new_cnt;
    if (!chg) begin
      single_total = tot_rd;
    end else if (cur.item.operation == smct_pkg::OP_ADD) begin
      single_total = tot_rd + 14'd1;
    end else begin
      single_total = tot_rd - 14'd1;
    end
  end

  always_comb begin
    logic [smct_pkg::CNT_W-1:0] c;
    set_word = '0;
    word_sum = '0;
    for (int s = 0; s < smct_pkg::SLOTS; s++) begin
      c = smct_pkg::merge_cnt(rd_a[2*s +: smct_pkg::CNT_W], rd_b[2*s +: smct_pkg::CNT_W],
                              cur.item.operation == smct_pkg::OP_UNION);
      set_word[2*s +: smct_pkg::CNT_W] = c;
      word_sum = word_sum + 5'(c);
    end
    set_total = acc + 14'(word_sum);
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    rd_en      = 1'b0;
    rd_addr_a  = {job_bank, job_word};
    rd_addr_b  = {job_other, {WAW{1'b0}}};
    we         = 1'b0;
    wr_addr    = {cur_bank, cur_word};
    wr_data    = single_word;
    tot_we     = 1'b0;
    tot_idx    = job_bank;
    tot_wdata  = single_total;
    emit       = 1'b0;
    emit_word  = '0;
    case (state)
      ST_CLEAR: begin
        we      = 1'b1;
        wr_addr = clr_addr;
        wr_data = '0;
        if (clr_addr == {AW{1'b1}}) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid) begin
          case (job.kind)
            smct_pkg::K_SINGLE: begin
              job_pop    = 1'b1;
              rd_en      = 1'b1;
              state_next = ST_SINGLE;
            end
            smct_pkg::K_SET: begin
              job_pop    = 1'b1;
              rd_en      = 1'b1;
              rd_addr_a  = {job_bank, {WAW{1'b0}}};
              state_next = ST_SET;
            end
            smct_pkg::K_REPORT: begin
              if (out_free) begin
                job_pop              = 1'b1;
                emit                 = 1'b1;
                emit_word.bank_total = tot_rd;
              end
            end
            default: begin
              if (out_free) begin
                job_pop = 1'b1;
                emit    = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SINGLE: begin
        tot_idx = cur_bank;
        if (out_free) begin
          we         = 1'b1;
          tot_we     = chg;
          emit       = 1'b1;
          emit_word  = '{element_count: new_cnt, bank_total: single_total, changed: chg};
          state_next = ST_IDLE;
        end
      end
      ST_SET: begin
        if (!last || out_free) begin
          we      = 1'b1;
          wr_addr = {cur_dest, word_idx};
          wr_data = set_word;
          if (last) begin
            tot_idx              = cur_dest;
            tot_we               = 1'b1;
            tot_wdata            = set_total;
            emit                 = 1'b1;
            emit_word.bank_total = set_total;
            state_next           = ST_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr_a = {cur_bank, next_word};
            rd_addr_b = {cur_other, next_word};
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < TOT_DEPTH; i++) begin
        totals[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (emit) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (tot_we) begin
        totals[tot_idx] <= tot_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      cur      <= job;
      word_idx <= '0;
      acc      <= '0;
    end else if (state == ST_SET && !last) begin
      word_idx <= next_word;
      acc      <= set_total;
    end
    if (emit) begin
      out_word <= emit_word;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a <= mem[rd_addr_a];
      rd_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

// ===== sv/saturating_multiset_counter_table_unit.sv =====
// Top level of the saturating multiset counter table: front queue and back execution part.
//
//   channel  | handshake                   | word
//   ---------+-----------------------------+----------------------------
//   item     | item_valid / item_ready     | smct_pkg::in_word_t  (in)
//   result   | result_valid / result_ready | smct_pkg::out_word_t (out)
//
// Add, remove and count do one memory read, then modify and write back.
// Intersect and union walk every word of the source banks, one word of both banks
// read per cycle through the two read ports. Unknown or out-of-range items skip memory.
// After reset a clearing pass writes every memory word, NUM_BANKS rounded up to a power
// of two times the words per bank rounded likewise (2048 words at the defaults);
// item_ready stays low throughout.
// A stalled result holds in the output register; the two-entry queue keeps taking items until it is full.
`default_nettype none
module saturating_multiset_counter_table_unit #(
  parameter int NUM_BANKS  = 4,
  parameter int NUM_VALUES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire smct_pkg::in_word_t  item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output smct_pkg::out_word_t      result
);

  logic           job_valid;
  logic           job_pop;
  logic           clear_done;
  smct_pkg::job_t job;

  smct_front #(
    .NUM_BANKS  (NUM_BANKS),
    .NUM_VALUES (NUM_VALUES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .clear_done (clear_done),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .job_valid  (job_valid),
    .job        (job),
    .job_pop    (job_pop)
  );

  smct_back #(
    .NUM_BANKS  (NUM_BANKS),
    .NUM_VALUES (NUM_VALUES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job          (job),
    .job_pop      (job_pop),
    .clear_done   (clear_done),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

// ===== sv/smct_checker.sv =====
// Port-level checker for the saturating multiset counter table, bound to the top level.
`default_nettype none
module smct_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                item_valid,
  input wire logic                item_ready,
  input wire logic                result_valid,
  input wire logic                result_ready,
  input wire smct_pkg::out_word_t result
);

  logic [2:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(item_valid && item_ready) - 3'(result_valid && result_ready);
    end
  end

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result word shown straight after reset");

  a_no_accept_after_reset: assert property (@(posedge clk) rst |=> !item_ready)
    else $error("item word taken before clearing pass");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pending != 3'd0)
    else $error("result word with no outstanding item");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("more outstanding words than the block can hold");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result word changed or dropped");

endmodule

bind saturating_multiset_counter_table_unit smct_checker u_smct_checker (.*);
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the saturating multiset counter table: directed and random traffic, table predictor.
`timescale 1ns / 100ps
module testbench;

  localparam int NUM_BANKS      = 4;
  localparam int NUM_VALUES     = 4096;
  localparam int WORDS_PER_BANK = (NUM_VALUES + 7) / 8;
  localparam int RANDOM_WORDS   = 1300;
  localparam int STALL_LIMIT    = 20000;
  localparam int SETTLE_CYCLES  = 600;

  localparam logic [2:0] OP_UNDEF_A = 3'd5;
  localparam logic [2:0] OP_UNDEF_B = 3'd6;
  localparam logic [2:0] OP_UNDEF_C = 3'd7;

  logic                clk;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  smct_pkg::in_word_t  item = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  smct_pkg::out_word_t result;

  saturating_multiset_counter_table_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  logic [smct_pkg::WORD_W-1:0] count_words [NUM_BANKS][WORDS_PER_BANK];
  int unsigned                 bank_sum [NUM_BANKS];

  smct_pkg::in_word_t  words_to_send [$];
  bit                  drain_first [$];
  smct_pkg::out_word_t due_results [$];

  bit          item_fired = 1'b0;
  bit          send_calm = 1'b0;
  bit          take_calm = 1'b0;
  int unsigned send_wait = 0;
  int unsigned take_wait = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned compared = 0;
  int unsigned op_seen [8];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic smct_pkg::out_word_t apply_to_table(input smct_pkg::in_word_t w);
    smct_pkg::out_word_t         r;
    logic [smct_pkg::CNT_W-1:0]  c;
    logic [smct_pkg::CNT_W-1:0]  ca;
    logic [smct_pkg::CNT_W-1:0]  cb;
    logic [smct_pkg::WORD_W-1:0] wa;
    logic [smct_pkg::WORD_W-1:0] wb;
    logic [smct_pkg::WORD_W-1:0] wr;
    int unsigned                 widx;
    int unsigned                 slot;
    int unsigned                 sum;
    int unsigned                 total;
    r = '0;
    case (w.operation)
      smct_pkg::OP_ADD, smct_pkg::OP_REMOVE, smct_pkg::OP_COUNT: begin
        widx = w.value >> 3;
        slot = w.value & 7;
        c = count_words[w.bank][widx][2*slot +: smct_pkg::CNT_W];
        if (w.operation == smct_pkg::OP_ADD && c != smct_pkg::COUNT_MAX) begin
          c = c + 2'd1;
          r.changed = 1'b1;
          bank_sum[w.bank] = bank_sum[w.bank] + 1;
        end else if (w.operation == smct_pkg::OP_REMOVE && c != 2'd0) begin
          c = c - 2'd1;
          r.changed = 1'b1;
          bank_sum[w.bank] = bank_sum[w.bank] - 1;
        end
        count_words[w.bank][widx][2*slot +: smct_pkg::CNT_W] = c;
        r.element_count = c;
        r.bank_total = bank_sum[w.bank][smct_pkg::TOTAL_W-1:0];
      end
      smct_pkg::OP_INTERSECT, smct_pkg::OP_UNION: begin
        total = 0;
        for (int i = 0; i < WORDS_PER_BANK; i++) begin
          wa = count_words[w.bank][i];
          wb = count_words[w.other_bank][i];
          wr = '0;
          for (int s = 0; s < smct_pkg::SLOTS; s++) begin
            ca = wa[2*s +: smct_pkg::CNT_W];
            cb = wb[2*s +: smct_pkg::CNT_W];
            if (w.operation == smct_pkg::OP_UNION) begin
              sum = ca + cb;
              if (sum > smct_pkg::COUNT_MAX) sum = smct_pkg::COUNT_MAX;
            end else begin
              sum = (ca < cb) ? ca : cb;
            end
            wr[2*s +: smct_pkg::CNT_W] = sum[smct_pkg::CNT_W-1:0];
            total = total + sum;
          end
          count_words[w.dest_bank][i] = wr;
        end
        bank_sum[w.dest_bank] = total;
        r.bank_total = total[smct_pkg::TOTAL_W-1:0];
      end
      default: begin
        r.bank_total = bank_sum[w.bank][smct_pkg::TOTAL_W-1:0];
      end
    endcase
    return r;
  endfunction

  function automatic int unsigned pause_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_word(input logic [2:0] op, input logic [1:0] b, input logic [11:0] v,
                            input logic [1:0] ob, input logic [1:0] db, input bit drain);
    smct_pkg::in_word_t w;
    w.operation  = op;
    w.bank       = b;
    w.value      = v;
    w.other_bank = ob;
    w.dest_bank  = db;
    words_to_send.push_back(w);
    drain_first.push_back(drain);
  endtask

  // sender: hold until taken, then gap or advance
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || item_fired) begin
      if (send_wait != 0) begin
        item_valid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (words_to_send.size() == 0 ||
                   (drain_first[0] && due_results.size() != 0)) begin
        item_valid <= 1'b0;
      end else begin
        item <= words_to_send.pop_front();
        void'(drain_first.pop_front());
        item_valid <= 1'b1;
        send_wait <= send_calm ? 0 : pause_len();
        if ($urandom_range(0, 79) == 0) send_calm <= !send_calm;
      end
    end
  end

  // receiver: stall at random
  always @(negedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (take_wait != 0) begin
      result_ready <= 1'b0;
      take_wait <= take_wait - 1;
    end else begin
      result_ready <= 1'b1;
      if (!take_calm && $urandom_range(0, 5) == 0) take_wait <= pause_len();
      if ($urandom_range(0, 199) == 0) take_calm <= !take_calm;
    end
  end

  always @(posedge clk) begin
    smct_pkg::out_word_t want;
    if (rst) begin
      item_fired <= 1'b0;
      idle_cycles <= 0;
    end else begin
      item_fired <= item_valid && item_ready;
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, result);
          mismatches = mismatches + 1;
        end else begin
          want = due_results.pop_front();
          compared = compared + 1;
          if (result.element_count !== want.element_count) begin
            $display("%0t: element_count expected %0d, got %0d",
                     $time, want.element_count, result.element_count);
            mismatches = mismatches + 1;
          end
          if (result.bank_total !== want.bank_total) begin
            $display("%0t: bank_total expected %0d, got %0d",
                     $time, want.bank_total, result.bank_total);
            mismatches = mismatches + 1;
          end
          if (result.changed !== want.changed) begin
            $display("%0t: changed expected %0b, got %0b",
                     $time, want.changed, result.changed);
            mismatches = mismatches + 1;
          end
        end
      end
      if (item_valid && item_ready) begin
        due_results.push_back(apply_to_table(item));
        op_seen[item.operation] = op_seen[item.operation] + 1;
      end
      if ((item_valid && item_ready) || (result_valid && result_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("testbench: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    logic [2:0]  op;
    logic [11:0] v;
    logic [11:0] window;
    int unsigned k;
    foreach (count_words[b, i]) count_words[b][i] = '0;
    foreach (bank_sum[b]) bank_sum[b] = 0;
    foreach (op_seen[o]) op_seen[o] = 0;

    repeat (4) queue_word(smct_pkg::OP_ADD, 2'd0, 12'd0, 2'd0, 2'd0, 1'b0);
    queue_word(smct_pkg::OP_COUNT, 2'd0, 12'd0, 2'd3, 2'd3, 1'b0);
    repeat (4) queue_word(smct_pkg::OP_REMOVE, 2'd0, 12'd0, 2'd0, 2'd0, 1'b0);
    queue_word(smct_pkg::OP_ADD, 2'd1, 12'd4095, 2'd0, 2'd0, 1'b0);
    queue_word(smct_pkg::OP_ADD, 2'd1, 12'd5, 2'd0, 2'd0, 1'b0);
    queue_word(smct_pkg::OP_ADD, 2'd3, 12'd7, 2'd0, 2'd0, 1'b0);
    queue_word(smct_pkg::OP_ADD, 2'd2, 12'd8, 2'd0, 2'd0, 1'b0);
    queue_word(smct_pkg::OP_ADD, 2'd0, 12'd5, 2'd0, 2'd0, 1'b0);
    queue_word(smct_pkg::OP_ADD, 2'd0, 12'd5, 2'd0, 2'd0, 1'b0);
    queue_word(smct_pkg::OP_INTERSECT, 2'd0, 12'd4095, 2'd1, 2'd2, 1'b0);
    queue_word(smct_pkg::OP_UNION, 2'd1, 12'd0, 2'd3, 2'd3, 1'b0);
    queue_word(smct_pkg::OP_UNION, 2'd3, 12'd0, 2'd3, 2'd3, 1'b1);
    queue_word(smct_pkg::OP_INTERSECT, 2'd0, 12'd0, 2'd1, 2'd0, 1'b0);
    queue_word(smct_pkg::OP_COUNT, 2'd3, 12'd4095, 2'd0, 2'd0, 1'b0);
    queue_word(smct_pkg::OP_COUNT, 2'd3, 12'd7, 2'd0, 2'd0, 1'b0);
    queue_word(OP_UNDEF_A, 2'd1, 12'd4095, 2'd3, 2'd3, 1'b0);
    queue_word(OP_UNDEF_B, 2'd3, 12'd0, 2'd0, 2'd0, 1'b0);
    queue_word(OP_UNDEF_C, 2'd3, 12'd4095, 2'd3, 2'd3, 1'b0);
    queue_word(smct_pkg::OP_REMOVE, 2'd2, 12'd4095, 2'd0, 2'd0, 1'b0);

    window = 12'($urandom_range(0, 4095 - 31));
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      k = $urandom_range(0, 99);
      if (k < 45) op = smct_pkg::OP_ADD;
      else if (k < 74) op = smct_pkg::OP_REMOVE;
      else if (k < 91) op = smct_pkg::OP_COUNT;
      else if (k < 94) op = smct_pkg::OP_INTERSECT;
      else if (k < 97) op = smct_pkg::OP_UNION;
      else begin
        k = $urandom_range(0, 2);
        op = (k == 0) ? OP_UNDEF_A : (k == 1) ? OP_UNDEF_B : OP_UNDEF_C;
      end
      if ($urandom_range(0, 63) == 0) window = 12'($urandom_range(0, 4095 - 31));
      if ($urandom_range(0, 9) < 7) v = 12'(window + $urandom_range(0, 31));
      else v = 12'($urandom_range(0, 4095));
      queue_word(op, 2'($urandom_range(0, 3)), v, 2'($urandom_range(0, 3)),
                 2'($urandom_range(0, 3)), (n % 250) == 249);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (words_to_send.size() == 0 && !item_valid);
    wait (due_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d add, %0d remove, %0d count, %0d intersect, %0d union, %0d undefined",
             op_seen[smct_pkg::OP_ADD], op_seen[smct_pkg::OP_REMOVE],
             op_seen[smct_pkg::OP_COUNT], op_seen[smct_pkg::OP_INTERSECT],
             op_seen[smct_pkg::OP_UNION],
             op_seen[OP_UNDEF_A] + op_seen[OP_UNDEF_B] + op_seen[OP_UNDEF_C]);
    $display("%0d results compared, %0d mismatches", compared, mismatches);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
